[hdl/rwt_pkg.sv]
package rwt_pkg;

   localparam int TIME_BITS_DEFAULT      = 32;
   localparam int SRTT_FRAC_BITS_DEFAULT = 3;

   localparam int FIELD_BITS     = 32;
   localparam int SEQ_BITS       = 32;
   localparam int COUNT_BITS     = 16;
   localparam int MULT_BITS      = 8;
   localparam int MIN_RTT_SHIFT  = 2;
   localparam int CSR_DATA_BITS  = 8;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DUP_ACK_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PERSIST_RELOAD    = 2'd1;

   localparam logic [CSR_DATA_BITS-1:0] DUP_ACK_THRESHOLD_RESET = 8'd3;
   localparam logic [CSR_DATA_BITS-1:0] PERSIST_RELOAD_RESET    = 8'd16;
   localparam logic [MULT_BITS-1:0]     PERSIST_RESET           = 8'd16;
   localparam logic [MULT_BITS-1:0]     MULT_RESET              = 8'd1;
   localparam logic [MULT_BITS-1:0]     MULT_MAX                = 8'hFF;

   typedef enum logic {
      CMD_ACK_SAMPLE    = 1'b0,
      CMD_WINDOW_UPDATE = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [FIELD_BITS-1:0] ts_echo;
      logic                  is_retrans;
      logic [FIELD_BITS-1:0] xmit_time;
      logic [SEQ_BITS-1:0]   seq_value;
      logic [SEQ_BITS-1:0]   next_seq;
      logic [FIELD_BITS-1:0] rtt_sample;
      logic                  reorder_seen;
      logic                  dsack_seen;
      logic                  in_recovery;
      logic [COUNT_BITS-1:0] sacked_count;
      logic                  exiting_recovery;
   } req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] reorder_window;
      logic [FIELD_BITS-1:0] min_rtt_out;
      logic [FIELD_BITS-1:0] srtt_out;
      logic [FIELD_BITS-1:0] newest_xmit_time;
      logic [SEQ_BITS-1:0]   newest_end_seq;
      logic                  sample_rejected;
   } rsp_type;

   function automatic logic seq_before(input logic [SEQ_BITS-1:0] a,
                                       input logic [SEQ_BITS-1:0] b);
      logic [SEQ_BITS-1:0] diff;
      diff = a - b;
      return diff[SEQ_BITS-1];
   endfunction

endpackage

[hdl/rack_reorder_window_tracker.sv]
// Tracks the RACK loss detection state of one flow: ack sample beats (cmd 0) update the
// latest, minimum and smoothed RTT and the most recently sent delivered packet, and window
// beats (cmd 1) handle DSACK widening and persistence and recompute the reordering window.
// Every accepted beat yields exactly one result beat carrying the updated state, which is
// registered in the output buffer. A new beat can be taken in every cycle while req_stall
// is low: the whole update is one registered pass whose longest path runs through the window
// multiplier, an 8-bit by TIME_BITS product and its compare against the smoothed RTT. A
// two-entry output buffer keeps input beats flowing while a result waits; req_stall rises
// only when both entries are occupied. Configuration writes take effect from the next cycle
// and should be made while no beat is in flight.
module rack_reorder_window_tracker #(
   parameter int TIME_BITS      = rwt_pkg::TIME_BITS_DEFAULT,
   parameter int SRTT_FRAC_BITS = rwt_pkg::SRTT_FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  rwt_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output rwt_pkg::rsp_type                   rsp_data,
   input  logic                               csr_wr_en,
   input  logic [rwt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rwt_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import rwt_pkg::*;

   logic    req_accept;
   logic    buffer_full;
   rsp_type core_result;

   assign req_stall  = buffer_full;
   assign req_accept = req_valid && !buffer_full;

   rwt_core #(
      .TIME_BITS      (TIME_BITS),
      .SRTT_FRAC_BITS (SRTT_FRAC_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .result    (core_result)
   );

   rwt_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (core_result),
      .full      (buffer_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present straight after reset");

   a_full_has_head: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("buffer reports full with no result presented");

   a_accept_shows: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted beat produced no result beat");

   a_window_not_rejected: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_data.cmd == CMD_WINDOW_UPDATE)) |-> !core_result.sample_rejected)
      else $error("window update beat flagged as rejected sample");
`endif

endmodule

[hdl/rwt_core.sv]
module rwt_core #(
   parameter int TIME_BITS      = rwt_pkg::TIME_BITS_DEFAULT,
   parameter int SRTT_FRAC_BITS = rwt_pkg::SRTT_FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  rwt_pkg::req_type                     req_data,
   input  logic                                 csr_wr_en,
   input  logic [rwt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rwt_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output rwt_pkg::rsp_type                     result
);
   import rwt_pkg::*;

   localparam int SCALED_BITS = TIME_BITS + SRTT_FRAC_BITS;
   localparam int PROD_BITS   = TIME_BITS + MULT_BITS;

   logic [CSR_DATA_BITS-1:0] dup_ack_threshold_ff, dup_ack_threshold_in;
   logic [CSR_DATA_BITS-1:0] persist_reload_ff, persist_reload_in;

   logic [TIME_BITS-1:0]   latest_xmit_time_ff, latest_xmit_time_in;
   logic [SEQ_BITS-1:0]    latest_end_seq_ff, latest_end_seq_in;
   logic [TIME_BITS-1:0]   latest_rtt_ff, latest_rtt_in;
   logic [TIME_BITS-1:0]   min_rtt_ff, min_rtt_in;
   logic [SEQ_BITS-1:0]    rtt_mark_seq_ff, rtt_mark_seq_in;
   logic [SCALED_BITS-1:0] srtt_scaled_ff, srtt_scaled_in;
   logic [TIME_BITS-1:0]   window_value_ff, window_value_in;
   logic [MULT_BITS-1:0]   window_multiplier_ff, window_multiplier_in;
   logic [MULT_BITS-1:0]   persist_left_ff, persist_left_in;

   logic [TIME_BITS-1:0]   ts_echo, xmit_time, rtt_sample, rtt_now, quarter_min, cap;
   logic [MULT_BITS-1:0]   persist_dec;
   logic [PROD_BITS-1:0]   product;
   logic                   rejected, newer, widen, clear_window;

   always_comb begin
      ts_echo    = TIME_BITS'(req_data.ts_echo);
      xmit_time  = TIME_BITS'(req_data.xmit_time);
      rtt_sample = TIME_BITS'(req_data.rtt_sample);

      dup_ack_threshold_in = dup_ack_threshold_ff;
      persist_reload_in    = persist_reload_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DUP_ACK_THRESHOLD: dup_ack_threshold_in = csr_wdata;
            CSR_PERSIST_RELOAD:    persist_reload_in = csr_wdata;
            default: ;
         endcase
      end

      latest_xmit_time_in  = latest_xmit_time_ff;
      latest_end_seq_in    = latest_end_seq_ff;
      latest_rtt_in        = latest_rtt_ff;
      min_rtt_in           = min_rtt_ff;
      rtt_mark_seq_in      = rtt_mark_seq_ff;
      srtt_scaled_in       = srtt_scaled_ff;
      window_value_in      = window_value_ff;
      window_multiplier_in = window_multiplier_ff;
      persist_left_in      = persist_left_ff;

      rejected = (req_data.cmd == CMD_ACK_SAMPLE) && req_data.is_retrans &&
                 ((ts_echo < xmit_time) || (rtt_sample < min_rtt_ff));

      rtt_now = (rtt_sample != '0) ? rtt_sample : latest_rtt_ff;
      newer   = (xmit_time > latest_xmit_time_ff) ||
                ((xmit_time == latest_xmit_time_ff) &&
                 seq_before(latest_end_seq_ff, req_data.seq_value));

      widen = req_data.dsack_seen && !seq_before(req_data.seq_value, rtt_mark_seq_ff);
      persist_dec = (persist_left_ff == '0) ? '0 : persist_left_ff - 1'b1;

      if (req_data.cmd == CMD_ACK_SAMPLE) begin
         if (!rejected) begin
            latest_rtt_in = rtt_now;
            if (rtt_sample != '0) begin
               rtt_mark_seq_in = req_data.next_seq;
            end
            if ((min_rtt_ff == '0) || (rtt_now < min_rtt_ff)) begin
               min_rtt_in = rtt_now;
            end
            if (srtt_scaled_ff == '0) begin
               srtt_scaled_in = SCALED_BITS'(rtt_now) << SRTT_FRAC_BITS;
            end else begin
               srtt_scaled_in = srtt_scaled_ff - (srtt_scaled_ff >> SRTT_FRAC_BITS) +
                                SCALED_BITS'(rtt_now);
            end
            if (newer) begin
               latest_xmit_time_in = xmit_time;
               latest_end_seq_in   = req_data.seq_value;
            end
         end
      end else begin
         if (widen) begin
            if (window_multiplier_ff != MULT_MAX) begin
               window_multiplier_in = window_multiplier_ff + 1'b1;
            end
            rtt_mark_seq_in = req_data.next_seq;
            persist_left_in = persist_reload_ff;
         end else if (req_data.exiting_recovery) begin
            persist_left_in = persist_dec;
            if (persist_dec == '0) begin
               window_multiplier_in = MULT_RESET;
            end
         end
      end

      quarter_min  = min_rtt_ff >> MIN_RTT_SHIFT;
      cap          = srtt_scaled_ff[SCALED_BITS-1:SRTT_FRAC_BITS];
      product      = PROD_BITS'(quarter_min) * PROD_BITS'(window_multiplier_in);
      clear_window = !req_data.reorder_seen &&
                     (req_data.in_recovery ||
                      (req_data.sacked_count >= COUNT_BITS'(dup_ack_threshold_ff)));
      if (req_data.cmd == CMD_WINDOW_UPDATE) begin
         if (clear_window) begin
            window_value_in = '0;
         end else if (product < PROD_BITS'(cap)) begin
            window_value_in = product[TIME_BITS-1:0];
         end else begin
            window_value_in = cap;
         end
      end

      result.reorder_window   = FIELD_BITS'(window_value_in);
      result.min_rtt_out      = FIELD_BITS'(min_rtt_in);
      result.srtt_out         = FIELD_BITS'(srtt_scaled_in[SCALED_BITS-1:SRTT_FRAC_BITS]);
      result.newest_xmit_time = FIELD_BITS'(latest_xmit_time_in);
      result.newest_end_seq   = latest_end_seq_in;
      result.sample_rejected  = rejected;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dup_ack_threshold_ff <= DUP_ACK_THRESHOLD_RESET;
         persist_reload_ff    <= PERSIST_RELOAD_RESET;
      end else begin
         dup_ack_threshold_ff <= dup_ack_threshold_in;
         persist_reload_ff    <= persist_reload_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latest_xmit_time_ff  <= '0;
         latest_end_seq_ff    <= '0;
         latest_rtt_ff        <= '0;
         min_rtt_ff           <= '0;
         rtt_mark_seq_ff      <= '0;
         srtt_scaled_ff       <= '0;
         window_value_ff      <= '0;
         window_multiplier_ff <= MULT_RESET;
         persist_left_ff      <= PERSIST_RESET;
      end else if (accept) begin
         latest_xmit_time_ff  <= latest_xmit_time_in;
         latest_end_seq_ff    <= latest_end_seq_in;
         latest_rtt_ff        <= latest_rtt_in;
         min_rtt_ff           <= min_rtt_in;
         rtt_mark_seq_ff      <= rtt_mark_seq_in;
         srtt_scaled_ff       <= srtt_scaled_in;
         window_value_ff      <= window_value_in;
         window_multiplier_ff <= window_multiplier_in;
         persist_left_ff      <= persist_left_in;
      end
   end

endmodule

[hdl/rwt_skid.sv]
module rwt_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rwt_pkg::rsp_type push_data,
   output logic             full,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rwt_pkg::rsp_type rsp_data
);
   import rwt_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    pop;

   always_comb begin
      pop           = out_valid_ff && !rsp_stall;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
